FILE: hw/rtl/oale_pkg.sv
// shared types, codes and sizes for the ordered array list engine
`default_nettype none
package oale_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int OPCODE_W   = 2;
  localparam int POSITION_W = 6;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int FOUND_W    = 5;
  localparam int COUNT_W    = 6;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_BAD_POSITION = 3'd2,
    ST_FULL         = 3'd3,
    ST_NOT_FOUND    = 3'd4
  } status_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [POSITION_W-1:0]     position;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_position;
    logic [COUNT_W-1:0]  element_count;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occupied;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ENC
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/oale_cell.sv
// one list cell: holds a word, shifts with its neighbours, compares against the key
`default_nettype none
module oale_cell (
  input  wire logic                               clk,
  input  wire oale_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [oale_pkg::VALUE_W-1:0] left_word,
  input  wire logic signed [oale_pkg::VALUE_W-1:0] right_word,
  input  wire logic signed [oale_pkg::VALUE_W-1:0] key,
  output logic signed [oale_pkg::VALUE_W-1:0]      word,
  output logic                                     match
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      oale_pkg::CELL_HOLD:  word <= word;
      oale_pkg::CELL_LEFT:  word <= left_word;
      oale_pkg::CELL_RIGHT: word <= right_word;
      oale_pkg::CELL_LOAD:  word <= key;
      default:              word <= word;
    endcase
  end

  // compare uses the contents before this cycle's shift
  always_ff @(posedge clk) begin
    match <= ctrl.occupied && (word == key);
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ordered_array_list_engine.sv
// top level: request decode, cell chain control, match encoder and result register
//
//   channel | signals                    | moves
//   req     | req_valid, req_ready, req  | opcode, position, value
//   rsp     | rsp_valid, rsp_ready, rsp  | status, found_position, element_count
//
// each request passes through accept, shift and compare in the cell chain,
// then lowest-match encode into the result register.
// a new request is accepted once the previous result sits in the result register.
// rsp_ready low holds the encode stage until the result register frees up.
// rst clears the element count, the control state and the result valid; cell
// contents are left as they are and only occupied cells are ever compared.
`default_nettype none
module ordered_array_list_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire oale_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output oale_pkg::rsp_t      rsp
);

  localparam int D = oale_pkg::LIST_DEPTH;

  oale_pkg::state_t            state, state_next;
  oale_pkg::req_t              cmd;
  logic [oale_pkg::CNT_W-1:0]  count, count_next;
  oale_pkg::status_t           st, st_next;

  logic exec_en;
  logic load_out;

  oale_pkg::cell_ctrl_t                 ctrl  [D];
  logic signed [oale_pkg::VALUE_W-1:0]  words [D];
  logic [D-1:0]                         hits;

  logic ins_ok, del_ok;
  int   pos_i, cnt_i;

  // request and operation checks
  always_comb begin
    pos_i      = int'(cmd.position);
    cnt_i      = int'(count);
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    st_next    = oale_pkg::ST_OK;
    count_next = count;
    case (cmd.opcode)
      oale_pkg::OP_INSERT: begin
        if (pos_i > cnt_i) begin
          st_next = oale_pkg::ST_BAD_POSITION;
        end else if (cnt_i >= D) begin
          st_next = oale_pkg::ST_FULL;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      oale_pkg::OP_DELETE: begin
        if (cnt_i == 0) begin
          st_next = oale_pkg::ST_EMPTY;
        end else if (pos_i >= cnt_i) begin
          st_next = oale_pkg::ST_BAD_POSITION;
        end else begin
          del_ok     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      oale_pkg::OP_FIND: begin
        if (cnt_i == 0) begin
          st_next = oale_pkg::ST_EMPTY;
        end
      end
      default: st_next = oale_pkg::ST_OK;
    endcase
  end

  // cell chain
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [oale_pkg::VALUE_W-1:0] lw, rw;

    always_comb begin
      ctrl[i].occupied = (i < cnt_i);
      ctrl[i].op       = oale_pkg::CELL_HOLD;
      if (exec_en && ins_ok) begin
        if (i > pos_i) begin
          ctrl[i].op = oale_pkg::CELL_LEFT;
        end else if (i == pos_i) begin
          ctrl[i].op = oale_pkg::CELL_LOAD;
        end
      end else if (exec_en && del_ok) begin
        if (i >= pos_i) begin
          ctrl[i].op = oale_pkg::CELL_RIGHT;
        end
      end
    end

    if (i == 0) begin : g_first
      assign lw = '0;
    end else begin : g_mid_l
      assign lw = words[i-1];
    end
    if (i == D - 1) begin : g_last
      assign rw = '0;
    end else begin : g_mid_r
      assign rw = words[i+1];
    end

    oale_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .left_word  (lw),
      .right_word (rw),
      .key        (cmd.value),
      .word       (words[i]),
      .match      (hits[i])
    );
  end

  // lowest matching cell
  logic [oale_pkg::FOUND_W-1:0] hit_pos;
  always_comb begin
    hit_pos = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_pos = oale_pkg::FOUND_W'(i);
      end
    end
  end

  logic find_ok;
  assign find_ok = (cmd.opcode == oale_pkg::OP_FIND) && (st == oale_pkg::ST_OK);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      oale_pkg::S_IDLE: if (req_valid) state_next = oale_pkg::S_EXEC;
      oale_pkg::S_EXEC: state_next = oale_pkg::S_ENC;
      oale_pkg::S_ENC:  if (!rsp_valid || rsp_ready) state_next = oale_pkg::S_IDLE;
      default:          state_next = oale_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    req_ready = 1'b0;
    exec_en   = 1'b0;
    load_out  = 1'b0;
    case (state)
      oale_pkg::S_IDLE: req_ready = 1'b1;
      oale_pkg::S_EXEC: exec_en   = 1'b1;
      oale_pkg::S_ENC:  load_out  = !rsp_valid || rsp_ready;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oale_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (exec_en) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= req;
    end
    if (exec_en) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status         <= (find_ok && !(|hits)) ? oale_pkg::ST_NOT_FOUND : st;
      rsp.found_position <= (find_ok && (|hits)) ? hit_pos : '0;
      rsp.element_count  <= oale_pkg::COUNT_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= D)
    else $error("element count beyond list depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == oale_pkg::S_EXEC)
    else $error("accepted request did not enter execute");

  a_count_only_exec: assert property (@(posedge clk) disable iff (rst)
    state != oale_pkg::S_EXEC |=> count == $past(count))
    else $error("element count changed outside execute");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found_position != '0 |-> rsp.status == oale_pkg::ST_OK)
    else $error("found position reported on a failed request");

endmodule
`default_nettype wire

FILE: sim/ordered_array_list_engine_tb.sv
`timescale 1ns / 100ps
// testbench for the ordered array list engine with a predicting list scoreboard
module ordered_array_list_engine_tb;
  import oale_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VALUE_POOL [8] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
    32'sh0000_0001, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0abc
  };

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} mix_t;

  class list_result_board;
    logic signed [VALUE_W-1:0] words [LIST_DEPTH];
    int unsigned held;
    rsp_t expected_rsp [$];
    int unsigned faults;

    function new();
      held = 0;
      faults = 0;
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    // work out the result of an accepted request and update the list copy
    function void note_request(req_t r);
      rsp_t exp_rsp;
      status_t st;
      int unsigned pos;
      int unsigned hit_at;
      int i;
      pos = 32'(r.position);
      hit_at = 0;
      st = ST_OK;
      case (r.opcode)
        OP_INSERT: begin
          if (pos > held) st = ST_BAD_POSITION;
          else if (held >= LIST_DEPTH) st = ST_FULL;
          else begin
            for (i = held; i > pos; i--) words[i] = words[i-1];
            words[pos] = r.value;
            held++;
          end
        end
        OP_DELETE: begin
          if (held == 0) st = ST_EMPTY;
          else if (pos >= held) st = ST_BAD_POSITION;
          else begin
            for (i = pos + 1; i < held; i++) words[i-1] = words[i];
            held--;
          end
        end
        OP_FIND: begin
          if (held == 0) st = ST_EMPTY;
          else begin
            st = ST_NOT_FOUND;
            for (i = 0; i < held; i++) begin
              if (st == ST_NOT_FOUND && words[i] == r.value) begin
                st = ST_OK;
                hit_at = i;
              end
            end
          end
        end
        default: st = ST_OK;
      endcase
      exp_rsp.status = st;
      exp_rsp.found_position = hit_at[FOUND_W-1:0];
      exp_rsp.element_count = held[COUNT_W-1:0];
      expected_rsp.push_back(exp_rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp_rsp;
      if (expected_rsp.size() == 0) begin
        flag($sformatf("unexpected result: status %0d pos %0d count %0d",
                       got.status, got.found_position, got.element_count));
        return;
      end
      exp_rsp = expected_rsp.pop_front();
      if (got.status !== exp_rsp.status ||
          got.found_position !== exp_rsp.found_position ||
          got.element_count !== exp_rsp.element_count) begin
        flag($sformatf("mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                       exp_rsp.status, exp_rsp.found_position, exp_rsp.element_count,
                       got.status, got.found_position, got.element_count));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  list_result_board sb;
  bit gaps_on;
  int unsigned stall_left;

  ordered_array_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= (stall_left == 1);
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  function automatic req_t make_req(logic [OPCODE_W-1:0] op, int unsigned pos,
                                    logic signed [VALUE_W-1:0] val);
    req_t r;
    r.opcode = op;
    r.position = pos[POSITION_W-1:0];
    r.value = val;
    return r;
  endfunction

  // mostly pool words or words already held, so finds hit and duplicates occur
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return VALUE_POOL[$urandom_range(0, 7)];
    if (roll < 70 && sb.held != 0) return sb.words[$urandom_range(0, sb.held - 1)];
    return $urandom;
  endfunction

  function automatic req_t pick_request(mix_t mix);
    req_t r;
    int unsigned roll;
    int unsigned held;
    held = sb.held;
    roll = $urandom_range(0, 99);
    r.value = pick_value();
    r.position = POSITION_W'($urandom_range(0, 63));
    case (mix)
      MIX_FILL:     r.opcode = roll < 70 ? OP_INSERT : (roll < 90 ? OP_FIND : OP_DELETE);
      MIX_DRAIN:    r.opcode = roll < 65 ? OP_DELETE : (roll < 85 ? OP_FIND : OP_INSERT);
      MIX_BALANCED: r.opcode = roll < 40 ? OP_INSERT : (roll < 75 ? OP_DELETE : OP_FIND);
      default:      r.opcode = roll < 10 ? OP_UNUSED : OPCODE_W'($urandom_range(0, 2));
    endcase
    // well-formed positions most of the time
    if (mix != MIX_NOISE && $urandom_range(0, 99) < 85) begin
      if (r.opcode == OP_INSERT) begin
        r.position = POSITION_W'($urandom_range(0, held));
      end else if (r.opcode == OP_DELETE && held != 0) begin
        r.position = POSITION_W'($urandom_range(0, held - 1));
      end
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic wait_all_results();
    req_valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned span;
    int unsigned phase;
    int unsigned roll;
    mix_t mix;
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    stall_left = 0;
    gaps_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list corners
    send_request(make_req(OP_FIND, 0, 32'sh0));
    send_request(make_req(OP_DELETE, 0, 32'sh0));
    send_request(make_req(OP_INSERT, 1, 32'sh1));
    send_request(make_req(OP_UNUSED, 63, 32'shffff_ffff));
    // build 0, min, -1, max, 0 through front, end and middle inserts
    send_request(make_req(OP_INSERT, 0, 32'sh8000_0000));
    send_request(make_req(OP_INSERT, 1, 32'sh7fff_ffff));
    send_request(make_req(OP_INSERT, 0, 32'sh0));
    send_request(make_req(OP_INSERT, 2, 32'shffff_ffff));
    send_request(make_req(OP_INSERT, 4, 32'sh0));
    send_request(make_req(OP_INSERT, 63, 32'sh2));
    send_request(make_req(OP_INSERT, 6, 32'sh3));
    // duplicate reports lowest position
    send_request(make_req(OP_FIND, 0, 32'sh0));
    send_request(make_req(OP_FIND, 0, 32'sh7fff_ffff));
    send_request(make_req(OP_FIND, 63, 32'sh8000_0000));
    send_request(make_req(OP_FIND, 0, 32'sh0000_3039));
    send_request(make_req(OP_DELETE, 5, 32'sh0));
    send_request(make_req(OP_DELETE, 63, 32'sh0));
    send_request(make_req(OP_UNUSED, 42, 32'sh5555_5555));
    send_request(make_req(OP_DELETE, 0, 32'sh0));
    send_request(make_req(OP_FIND, 0, 32'sh0));
    send_request(make_req(OP_DELETE, 3, 32'shaaaa_aaaa));
    send_request(make_req(OP_DELETE, 1, 32'sh0));
    send_request(make_req(OP_FIND, 0, 32'shffff_ffff));
    wait_all_results();

    sent = 0;
    phase = 0;
    while (sent < 700) begin
      roll = $urandom_range(0, 9);
      if (phase == 0) mix = MIX_FILL;
      else if (phase == 1) mix = MIX_DRAIN;
      else if (roll < 3) mix = MIX_FILL;
      else if (roll < 6) mix = MIX_DRAIN;
      else if (roll < 9) mix = MIX_BALANCED;
      else mix = MIX_NOISE;
      span = $urandom_range(40, 120);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (span) send_request(pick_request(mix));
      sent += span;
      // after phase 0, and at random later, the sender waits for every result
      if (phase == 0 || $urandom_range(0, 2) == 0) wait_all_results();
      phase++;
    end

    gaps_on = 1'b0;
    repeat (100) send_request(pick_request(MIX_BALANCED));
    wait_all_results();
    repeat (10) @(posedge clk);

    if (sb.faults == 0 && sb.expected_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
